@@ design/pulse_width_stats_table_unit_macros.svh @@
// Assertion macros for the pulse width statistics table.
`ifndef PULSE_WIDTH_STATS_TABLE_UNIT_MACROS_SVH
`define PULSE_WIDTH_STATS_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication on clk_i, quiet during reset.
`define PWST_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pwst assertion failed");
// Next-cycle implication on clk_i, quiet during reset.
`define PWST_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pwst assertion failed");
`else
`define PWST_ASSERT_NOW(lbl, pre, post)
`define PWST_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ design/pwst_pkg.sv @@
// Shared types, constants and the width binning function.
package pwst_pkg;

  localparam int unsigned MAX_SENSORS_DEF = 8;
  localparam int unsigned HIST_BUCKETS    = 13;
  localparam int unsigned BIN_W           = 4;

  typedef enum logic [2:0] {
    OP_PULSE       = 3'd0,
    OP_EMPTY       = 3'd1,
    OP_ERROR       = 3'd2,
    OP_TICK        = 3'd3,
    OP_CLEAR_STATS = 3'd4,
    OP_READ_SENSOR = 3'd5,
    OP_READ_BUCKET = 3'd6,
    OP_CLEAR_ALL   = 3'd7
  } op_e;

  localparam logic [1:0] ERR_CHECKSUM = 2'd0;
  localparam logic [1:0] ERR_PRESENCE = 2'd1;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef logic [7:0] limit_arr_t [HIST_BUCKETS-1];
  localparam limit_arr_t BUCKET_LIMIT = '{
    8'd2, 8'd4, 8'd6, 8'd9, 8'd12, 8'd14, 8'd19, 8'd24, 8'd29, 8'd39, 8'd49, 8'd59
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] rom_id;
    logic        rom_present;
    logic [7:0]  pulse_width;
    logic        last_pulse;
    logic [1:0]  error_kind;
    logic [3:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  sensor_slot;
    logic [63:0] rom_out;
    logic [7:0]  min_width;
    logic [7:0]  max_width;
    logic [31:0] capture_count;
    logic [31:0] error_sum;
    logic [31:0] bucket_count;
    logic [31:0] cycle_total;
    logic [31:0] error_total;
    logic        entry_valid;
  } out_word_t;

  // Classified word passed from front to back.
  typedef struct packed {
    op_e              op;
    logic [63:0]      rom_id;
    logic             rom_present;
    logic [7:0]       pulse_width;
    logic             last_pulse;
    logic [1:0]       error_kind;
    logic [3:0]       read_index;
    logic [BIN_W-1:0] bin;
  } cls_t;

  // First bucket whose limit is not below the width; last bucket otherwise.
  function automatic logic [BIN_W-1:0] width_bin(input logic [7:0] w);
    logic [BIN_W-1:0] b;
    b = BIN_W'(HIST_BUCKETS - 1);
    for (int i = HIST_BUCKETS - 2; i >= 0; i--) begin
      if (w <= BUCKET_LIMIT[i]) b = BIN_W'(i);
    end
    return b;
  endfunction

endpackage

@@ design/pulse_width_stats_table_unit.sv @@
// Top level of the pulse width statistics table.
// Each input word gives exactly one output word. The front end decodes the
// opcode and bins the pulse width into one of 13 buckets, then parks the word
// in a two-entry queue; the back end pops a word, compares its identifier
// against every allocated slot and registers the match, then in its execute
// state applies the update and loads the result register, waiting there while
// a held result is not taken. The back end pops no new word until that update
// is done, since the next lookup must see any slot the previous word allocated.
// A word passes the queue, the lookup registers and the output register before
// output valid rises. The output register lets the next words queue up while a
// result waits to be taken. Identifiers in unallocated slots are never read
// out; all counters wrap at 32 bits.
`include "pulse_width_stats_table_unit_macros.svh"
module pulse_width_stats_table_unit #(
  parameter int unsigned MaxSensors = pwst_pkg::MAX_SENSORS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwst_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwst_pkg::out_word_t out_word_o
);
  import pwst_pkg::*;

  logic q_valid, q_pop;
  cls_t q_word;

  pwst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_word_o   (q_word),
    .q_pop_i    (q_pop)
  );

  pwst_back #(.MaxSensors(MaxSensors)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // an accepted word is still queued on the next cycle
  `PWST_ASSERT_NEXT(a_queue_fill, in_valid_i && !in_stall_o, q_valid)
  // error sum only appears on a valid sensor read
  `PWST_ASSERT_NOW(a_esum_valid, out_valid_o && (out_word_o.error_sum != 32'd0),
                   out_word_o.entry_valid)
  // bucket data only appears on a valid bucket read
  `PWST_ASSERT_NOW(a_bucket_valid, out_valid_o && (out_word_o.bucket_count != 32'd0),
                   out_word_o.entry_valid)
endmodule

@@ design/pwst_front.sv @@
// Front end: decodes and bins each input word into a two-entry queue.
module pwst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pwst_pkg::in_word_t in_word_i,
  output logic             q_valid_o,
  output pwst_pkg::cls_t   q_word_o,
  input  logic             q_pop_i
);
  import pwst_pkg::*;

  cls_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cls_t       cls;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = mem_q[rd_ptr_q];

  always_comb begin
    cls.op          = op_e'(in_word_i.opcode);
    cls.rom_id      = in_word_i.rom_id;
    cls.rom_present = in_word_i.rom_present;
    cls.pulse_width = in_word_i.pulse_width;
    cls.last_pulse  = in_word_i.last_pulse;
    cls.error_kind  = in_word_i.error_kind;
    cls.read_index  = in_word_i.read_index;
    cls.bin         = width_bin(in_word_i.pulse_width);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

@@ design/pwst_back.sv @@
// Back end: identifier lookup, table update and the output register.
module pwst_back #(
  parameter int unsigned MaxSensors = pwst_pkg::MAX_SENSORS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  pwst_pkg::cls_t     q_word_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pwst_pkg::out_word_t out_word_o
);
  import pwst_pkg::*;

  localparam int unsigned SW = $clog2(MaxSensors + 1);
  localparam int unsigned IW = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;

  bk_state_e state_q, state_d;
  cls_t      cur_q;
  logic [MaxSensors-1:0] match_q, match_d;

  logic [63:0] ids_q  [MaxSensors];
  logic [7:0]  min_q  [MaxSensors];
  logic [7:0]  max_q  [MaxSensors];
  logic [31:0] cap_q  [MaxSensors];
  logic [31:0] chk_q  [MaxSensors];
  logic [31:0] prs_q  [MaxSensors];
  logic [31:0] oth_q  [MaxSensors];
  logic [31:0] hist_q [HIST_BUCKETS];
  logic [SW-1:0] used_q;
  logic [31:0] cycles_q, errors_q, cycles_d, errors_d;

  logic      out_valid_q;
  out_word_t out_q, out_d;

  logic          exec, hit, uses_slot, alloc, slot_ok, rd_ok, bk_ok, is_clear, wr_mm;
  logic [IW-1:0] hit_idx, slot_idx, addr;
  logic [7:0]    cur_min, cur_max, new_min, new_max, slot8;

  // lookup against live entries, registered for the execute cycle
  always_comb begin
    for (int i = 0; i < MaxSensors; i++) begin
      match_d[i] = q_word_i.rom_present && (SW'(i) < used_q) &&
                   (ids_q[i] == q_word_i.rom_id);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = MaxSensors - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IW'(i);
    end
  end

  always_comb begin
    exec      = (state_q == BK_EXEC) && !(out_valid_q && out_stall_i);
    q_pop_o   = (state_q == BK_IDLE) && q_valid_i;
    state_d   = state_q;
    case (state_q)
      BK_IDLE: if (q_valid_i) state_d = BK_EXEC;
      BK_EXEC: if (exec) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase

    hit       = |match_q;
    uses_slot = (cur_q.op == OP_PULSE) || (cur_q.op == OP_EMPTY) ||
                (cur_q.op == OP_ERROR);
    alloc     = uses_slot && cur_q.rom_present && !hit && (used_q < SW'(MaxSensors));
    slot_ok   = uses_slot && cur_q.rom_present && (hit || alloc);
    slot_idx  = hit ? hit_idx : IW'(used_q);
    rd_ok     = (cur_q.op == OP_READ_SENSOR) && ({4'b0, cur_q.read_index} < 8'(used_q));
    bk_ok     = (cur_q.op == OP_READ_BUCKET) && (cur_q.read_index < 4'(HIST_BUCKETS));
    is_clear  = (cur_q.op == OP_CLEAR_STATS) || (cur_q.op == OP_CLEAR_ALL);
    addr      = rd_ok ? IW'(cur_q.read_index) : slot_idx;

    cur_min   = alloc ? 8'hFF : min_q[addr];
    cur_max   = alloc ? 8'h00 : max_q[addr];
    new_min   = ((cur_q.op == OP_PULSE) && (cur_q.pulse_width < cur_min)) ?
                cur_q.pulse_width : cur_min;
    new_max   = ((cur_q.op == OP_PULSE) && (cur_q.pulse_width > cur_max)) ?
                cur_q.pulse_width : cur_max;
    wr_mm     = slot_ok && (alloc || (cur_q.op == OP_PULSE));

    cycles_d  = is_clear ? 32'd0 : (cur_q.op == OP_TICK) ? cycles_q + 32'd1 : cycles_q;
    errors_d  = is_clear ? 32'd0 : (cur_q.op == OP_ERROR) ? errors_q + 32'd1 : errors_q;

    slot8     = slot_ok ? 8'(slot_idx) : rd_ok ? 8'(cur_q.read_index) : 8'(MaxSensors);

    out_d               = '0;
    out_d.sensor_slot   = slot8[3:0];
    out_d.cycle_total   = cycles_d;
    out_d.error_total   = errors_d;
    if (rd_ok) begin
      out_d.rom_out       = ids_q[addr];
      out_d.min_width     = min_q[addr];
      out_d.max_width     = max_q[addr];
      out_d.capture_count = cap_q[addr];
      out_d.error_sum     = chk_q[addr] + prs_q[addr] + oth_q[addr];
      out_d.entry_valid   = 1'b1;
    end
    if (bk_ok) begin
      out_d.bucket_count  = hist_q[cur_q.read_index];
      out_d.entry_valid   = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q   <= q_word_i;
      match_q <= match_d;
    end
    if (exec && alloc) ids_q[slot_idx] <= cur_q.rom_id;
    if (exec) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      cycles_q    <= '0;
      errors_q    <= '0;
      for (int i = 0; i < MaxSensors; i++) begin
        min_q[i] <= 8'hFF;
        max_q[i] <= 8'h00;
        cap_q[i] <= '0;
        chk_q[i] <= '0;
        prs_q[i] <= '0;
        oth_q[i] <= '0;
      end
      for (int b = 0; b < HIST_BUCKETS; b++) hist_q[b] <= '0;
    end else begin
      state_q <= state_d;
      if (exec) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (exec) begin
        cycles_q <= cycles_d;
        errors_q <= errors_d;
        if (alloc) used_q <= used_q + SW'(1);
        if (wr_mm) begin
          min_q[slot_idx] <= new_min;
          max_q[slot_idx] <= new_max;
        end
        case (cur_q.op)
          OP_PULSE: begin
            hist_q[cur_q.bin] <= hist_q[cur_q.bin] + 32'd1;
            if (slot_ok && cur_q.last_pulse) cap_q[slot_idx] <= cap_q[slot_idx] + 32'd1;
          end
          OP_EMPTY: begin
            if (slot_ok) cap_q[slot_idx] <= cap_q[slot_idx] + 32'd1;
          end
          OP_ERROR: begin
            if (slot_ok) begin
              if (cur_q.error_kind == ERR_CHECKSUM)
                chk_q[slot_idx] <= chk_q[slot_idx] + 32'd1;
              else if (cur_q.error_kind == ERR_PRESENCE)
                prs_q[slot_idx] <= prs_q[slot_idx] + 32'd1;
              else
                oth_q[slot_idx] <= oth_q[slot_idx] + 32'd1;
            end
          end
          OP_CLEAR_STATS, OP_CLEAR_ALL: begin
            for (int i = 0; i < MaxSensors; i++) begin
              min_q[i] <= 8'hFF;
              max_q[i] <= 8'h00;
              cap_q[i] <= '0;
              chk_q[i] <= '0;
              prs_q[i] <= '0;
              oth_q[i] <= '0;
            end
            for (int b = 0; b < HIST_BUCKETS; b++) hist_q[b] <= '0;
            if (cur_q.op == OP_CLEAR_ALL) used_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

@@ sim/tb_top.sv @@
// Testbench for the pulse width statistics table: table-driven directed words, then random words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pwst_pkg::*;

  localparam int unsigned NSLOT = MAX_SENSORS_DEF;
  localparam int unsigned N_RANDOM = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  always #4 clk_i = ~clk_i;

  pulse_width_stats_table_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  // Shadow copy of the table state.
  logic [63:0] ids_q [NSLOT];
  logic [7:0] mins_q [NSLOT];
  logic [7:0] maxs_q [NSLOT];
  logic [31:0] caps_q [NSLOT];
  logic [31:0] crc_errs_q [NSLOT];
  logic [31:0] pres_errs_q [NSLOT];
  logic [31:0] oth_errs_q [NSLOT];
  logic [31:0] hist_q [HIST_BUCKETS];
  int unsigned used_q;
  logic [31:0] cycles_q;
  logic [31:0] errs_q;

  out_word_t results_due [$];
  int unsigned n_fail = 0;
  int unsigned n_words = 0;
  int unsigned n_results = 0;
  bit idle_on = 1'b1;

  function automatic int unsigned bin_of(logic [7:0] w);
    logic [7:0] lim [12] = '{2, 4, 6, 9, 12, 14, 19, 24, 29, 39, 49, 59};
    for (int i = 0; i < 12; i++) begin
      if (w <= lim[i]) return i;
    end
    return 12;
  endfunction

  function automatic void wipe_stats();
    for (int i = 0; i < NSLOT; i++) begin
      mins_q[i] = 8'hFF;
      maxs_q[i] = '0;
      caps_q[i] = '0;
      crc_errs_q[i] = '0;
      pres_errs_q[i] = '0;
      oth_errs_q[i] = '0;
    end
    for (int i = 0; i < HIST_BUCKETS; i++) hist_q[i] = '0;
    cycles_q = '0;
    errs_q = '0;
  endfunction

  function automatic int unsigned find_slot(logic present, logic [63:0] id);
    if (!present) return NSLOT;
    for (int i = 0; i < used_q; i++) begin
      if (ids_q[i] == id) return i;
    end
    if (used_q < NSLOT) begin
      ids_q[used_q] = id;
      mins_q[used_q] = 8'hFF;
      maxs_q[used_q] = '0;
      used_q++;
      return used_q - 1;
    end
    return NSLOT;
  endfunction

  // Applies one word to the shadow state and returns the result it gives.
  function automatic out_word_t table_update(in_word_t w);
    out_word_t r;
    int unsigned s;
    r = '0;
    s = NSLOT;
    case (op_e'(w.opcode))
      OP_PULSE: begin
        s = find_slot(w.rom_present, w.rom_id);
        hist_q[bin_of(w.pulse_width)]++;
        if (s < NSLOT) begin
          if (w.pulse_width < mins_q[s]) mins_q[s] = w.pulse_width;
          if (w.pulse_width > maxs_q[s]) maxs_q[s] = w.pulse_width;
          if (w.last_pulse) caps_q[s]++;
        end
      end
      OP_EMPTY: begin
        s = find_slot(w.rom_present, w.rom_id);
        if (s < NSLOT) caps_q[s]++;
      end
      OP_ERROR: begin
        s = find_slot(w.rom_present, w.rom_id);
        if (s < NSLOT) begin
          if (w.error_kind == ERR_CHECKSUM) crc_errs_q[s]++;
          else if (w.error_kind == ERR_PRESENCE) pres_errs_q[s]++;
          else oth_errs_q[s]++;
        end
        errs_q++;
      end
      OP_TICK: cycles_q++;
      OP_CLEAR_STATS: wipe_stats();
      OP_READ_SENSOR: begin
        if (w.read_index < used_q) begin
          s = w.read_index;
          r.rom_out = ids_q[s];
          r.min_width = mins_q[s];
          r.max_width = maxs_q[s];
          r.capture_count = caps_q[s];
          r.error_sum = crc_errs_q[s] + pres_errs_q[s] + oth_errs_q[s];
          r.entry_valid = 1'b1;
        end
      end
      OP_READ_BUCKET: begin
        if (w.read_index < HIST_BUCKETS) begin
          r.bucket_count = hist_q[w.read_index];
          r.entry_valid = 1'b1;
        end
      end
      default: begin
        wipe_stats();
        used_q = 0;
      end
    endcase
    r.sensor_slot = 4'(s);
    r.cycle_total = cycles_q;
    r.error_total = errs_q;
    return r;
  endfunction

  function automatic in_word_t mk(op_e op, logic [63:0] id, logic pr, logic [7:0] pw,
                                  logic lp, logic [1:0] ek, logic [3:0] ri);
    in_word_t w;
    w.opcode = op;
    w.rom_id = id;
    w.rom_present = pr;
    w.pulse_width = pw;
    w.last_pulse = lp;
    w.error_kind = ek;
    w.read_index = ri;
    return w;
  endfunction

  // Directed rows; a typed result is checked as well as the predictor's.
  typedef struct {
    in_word_t w;
    bit has_exp;
    out_word_t exp;
  } row_t;
  row_t rows [$];

  task automatic add_row(in_word_t w, bit has_exp = 1'b0, out_word_t e = '0);
    row_t r;
    r.w = w;
    r.has_exp = has_exp;
    r.exp = e;
    rows.push_back(r);
  endtask

  // Issue one word and wait for it to be taken.
  task automatic send_word(in_word_t w);
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    results_due.push_back(table_update(w));
    n_words++;
  endtask

  logic [63:0] id_pool [12];

  function automatic in_word_t rand_word();
    in_word_t w;
    int unsigned p;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    p = $urandom_range(99);
    // Mostly traffic on a pool of known devices, so the table fills and reads hit.
    if (p < 45) w.opcode = OP_PULSE;
    else if (p < 52) w.opcode = OP_EMPTY;
    else if (p < 60) w.opcode = OP_ERROR;
    else if (p < 68) w.opcode = OP_TICK;
    else if (p < 80) w.opcode = OP_READ_SENSOR;
    else if (p < 92) w.opcode = OP_READ_BUCKET;
    else if (p < 96) w.opcode = OP_CLEAR_STATS;
    else if (p < 98) w.opcode = OP_CLEAR_ALL;
    if ($urandom_range(9) < 8) w.rom_id = id_pool[$urandom_range(11)];
    if ($urandom_range(9) < 8) w.rom_present = 1'b1;
    if ($urandom_range(3) != 0) w.pulse_width = 8'($urandom_range(70));
    return w;
  endfunction

  initial begin
    out_word_t e;
    wipe_stats();
    used_q = 0;
    for (int i = 0; i < 12; i++) id_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads straight after reset: empty table, empty bucket.
    add_row(mk(OP_READ_SENSOR, '0, 1'b0, '0, 1'b0, '0, 4'd0), 1'b1,
            '{sensor_slot: 4'(NSLOT), default: '0});
    e = '0;
    e.entry_valid = 1'b1;
    e.sensor_slot = 4'(NSLOT);
    add_row(mk(OP_READ_BUCKET, '0, 1'b0, '0, 1'b0, '0, 4'd12), 1'b1, e);
    add_row(mk(OP_READ_BUCKET, '0, 1'b0, '0, 1'b0, '0, 4'd15), 1'b1,
            '{sensor_slot: 4'(NSLOT), default: '0});
    // Width extremes and bucket edges, first pulse allocates slot 0.
    add_row(mk(OP_PULSE, '1, 1'b1, 8'd0, 1'b0, '0, '0), 1'b1, '0);
    add_row(mk(OP_PULSE, '1, 1'b1, 8'd255, 1'b1, '0, '0));
    add_row(mk(OP_PULSE, '1, 1'b1, 8'd59, 1'b0, '0, '0));
    add_row(mk(OP_PULSE, '1, 1'b1, 8'd60, 1'b0, '0, '0));
    // No identifier: histogram only.
    add_row(mk(OP_PULSE, 64'h5, 1'b0, 8'd3, 1'b1, '0, '0));
    add_row(mk(OP_EMPTY, 64'h0, 1'b1, '0, 1'b0, '0, '0));
    for (int k = 0; k < 4; k++)
      add_row(mk(OP_ERROR, 64'h0, 1'b1, '0, 1'b0, 2'(k), '0));
    add_row(mk(OP_ERROR, 64'h9, 1'b0, '0, 1'b0, 2'd3, '0));
    add_row(mk(OP_TICK, '0, 1'b0, '0, 1'b0, '0, '0));
    // Fill the table, then one more unknown device finds it full.
    for (int k = 2; k < 9; k++)
      add_row(mk(OP_PULSE, 64'(k) << 56, 1'b1, 8'(k), 1'b1, '0, '0));
    add_row(mk(OP_READ_SENSOR, '0, 1'b0, '0, 1'b0, '0, 4'd0));
    add_row(mk(OP_READ_SENSOR, '0, 1'b0, '0, 1'b0, '0, 4'd8));
    add_row(mk(OP_CLEAR_STATS, '0, 1'b0, '0, 1'b0, '0, '0));
    add_row(mk(OP_READ_SENSOR, '0, 1'b0, '0, 1'b0, '0, 4'd7));
    add_row(mk(OP_CLEAR_ALL, '0, 1'b0, '0, 1'b0, '0, '0));

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].has_exp && results_due[$] !== rows[i].exp) begin
        $display("%0t: directed row %0d expected %h predicted %h", $time, i,
                 rows[i].exp, results_due[$]);
        n_fail++;
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // A stretch in the middle runs without any idling.
      idle_on = !(i >= 600 && i < 900);
      send_word(rand_word());
    end
    in_valid_i <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words (%0d directed), checked %0d results.", n_words,
             rows.size(), n_results);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stall, with the same quiet stretch as the sender.
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: result %h with none expected", $time, out_word_o);
        n_fail++;
      end else begin
        out_word_t e;
        e = results_due.pop_front();
        n_results++;
        if (out_word_o.sensor_slot !== e.sensor_slot ||
            out_word_o.rom_out !== e.rom_out ||
            out_word_o.min_width !== e.min_width ||
            out_word_o.max_width !== e.max_width ||
            out_word_o.capture_count !== e.capture_count ||
            out_word_o.error_sum !== e.error_sum ||
            out_word_o.bucket_count !== e.bucket_count ||
            out_word_o.cycle_total !== e.cycle_total ||
            out_word_o.error_total !== e.error_total ||
            out_word_o.entry_valid !== e.entry_valid) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_word_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/pwst_pkg.sv
design/pwst_front.sv
design/pwst_back.sv
design/pulse_width_stats_table_unit.sv
sim/tb_top.sv
